// ===== hdl/dfdl_pkg.sv =====
// ----------------------------------------------------------------------------
// dfdl_pkg
// Shared widths, reset values, register codes and tanh constants for the
// damped feedback delay line.
// ----------------------------------------------------------------------------
package dfdl_pkg;

  // default geometry
  localparam int DFDL_DEPTH    = 131072;
  localparam int DFDL_CHANNELS = 2;

  // word fields
  localparam int CH_W     = 1;
  localparam int SAMPLE_W = 24;

  // configuration registers
  localparam int DELAY_W    = 25;
  localparam int COEF_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [DELAY_W-1:0] DELAY_RST = 25'd6758400;
  localparam logic [COEF_W-1:0]  FB_RST    = 17'd39322;
  localparam logic [COEF_W-1:0]  DAMP_RST  = 17'd13107;
  localparam logic [COEF_W-1:0]  COEF_ONE  = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_Q8      = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_DAMP_COEFF    = 2'd2
  } cfg_reg_t;

  // datapath
  localparam int FRAC_W   = 8;   // fraction bits of the delay
  localparam int LP_W     = 32;  // damping state, Q1.31
  localparam int TANH_Q   = 23;
  localparam int Q_W      = 24;  // tanh magnitude / quotient width
  localparam int ND_W     = 34;  // Pade numerator / denominator width
  localparam int DIV_BITS = 2;   // quotient bits per divider cycle
  localparam int DIV_STEPS = Q_W / DIV_BITS;

  // 945 * 2^23 and the Pade weights
  localparam logic [ND_W-1:0] PADE_C0   = 34'd7927234560;
  localparam logic [ND_W-1:0] PADE_N2   = 34'd105;
  localparam logic [ND_W-1:0] PADE_D2   = 34'd420;
  localparam logic [ND_W-1:0] PADE_D4   = 34'd15;

endpackage

// ===== hdl/dfdl_if.sv =====
// ----------------------------------------------------------------------------
// dfdl_in_if / dfdl_out_if
// Valid/ready channels carrying input and result words of the delay line.
// ----------------------------------------------------------------------------
interface dfdl_in_if;
  import dfdl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

interface dfdl_out_if;
  import dfdl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel_out;
  logic signed [SAMPLE_W-1:0] delayed_out;

  modport source (output valid, output channel_out, output delayed_out, input ready);
  modport sink   (input valid, input channel_out, input delayed_out, output ready);
endinterface

// ===== hdl/damped_feedback_delay_line_unit.sv =====
// ----------------------------------------------------------------------------
// damped_feedback_delay_line_unit
// Per-channel feedback delay with a one-pole damping lowpass and a Pade tanh
// in the feedback path.
// ----------------------------------------------------------------------------
// One word is handled at a time. A word accepted on in_chan raises out_chan
// valid once the sequencer has reached S_OUT and loaded the output register
// (later if an earlier result still waits on out_chan); the next input word
// is taken after the sequencer returns to S_IDLE. The pace is set by the
// sequencer around the delay memory (two reads and one write per word) and
// by the 2-bit-per-cycle divider that forms the tanh ratio. A finished result
// sits in an output register, so a stalled sink only holds the block at the
// point where the next result is loaded. There is no clearing pass after
// reset: each channel tracks whether its write pointer has wrapped, and
// memory entries not yet written read as zero. Configuration writes are
// taken at any time and should land while idle.
// ----------------------------------------------------------------------------
module damped_feedback_delay_line_unit #(
  parameter int DEPTH    = dfdl_pkg::DFDL_DEPTH,
  parameter int CHANNELS = dfdl_pkg::DFDL_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dfdl_in_if.sink                          in_chan,
  dfdl_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [dfdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfdl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dfdl_pkg::*;

  localparam int PW        = $clog2(DEPTH);
  localparam int RPW       = PW + FRAC_W + 1;
  localparam int CW        = (RPW > DELAY_W) ? RPW : DELAY_W;
  localparam int MEM_DEPTH = CHANNELS * DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CW-1:0]  DMAX     = CW'((DEPTH - 1) * 256);
  localparam logic [RPW-1:0] SPAN     = RPW'(DEPTH * 256);
  localparam logic [PW-1:0]  WP_LAST  = PW'(DEPTH - 1);
  localparam logic [AW-1:0]  CH1_BASE = AW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_ADDR, S_RDA, S_RDB, S_DIFF, S_OUT, S_LP1, S_LP2, S_ARG,
    S_ABS, S_X2, S_X4, S_ND, S_MUL, S_DIV, S_WB
  } state_t;

  // configuration registers
  logic [DELAY_W-1:0] delay_q8_r;
  logic [COEF_W-1:0]  fb_gain_r;
  logic [COEF_W-1:0]  damp_coeff_r;

  // per-channel state
  logic [PW-1:0]          wp_r      [CHANNELS];
  logic                   wrapped_r [CHANNELS];
  logic signed [LP_W-1:0] damp_r    [CHANNELS];

  // sequencer and datapath registers
  state_t                     state_r;
  logic [CH_W-1:0]            ch_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       skip_r;
  logic [PW-1:0]              idx_r;
  logic [PW-1:0]              idxb_r;
  logic [FRAC_W-1:0]          f_r;
  logic                       a_ok_r;
  logic                       b_ok_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [33:0]         prod_r;
  logic signed [SAMPLE_W-1:0] delayed_r;
  logic signed [50:0]         lp_prod_r;
  logic signed [LP_W-1:0]     s_r;
  logic signed [49:0]         arg_prod_r;
  logic                       neg_r;
  logic [Q_W-1:0]             ax_r;
  logic [Q_W-1:0]             x2_r;
  logic [Q_W-1:0]             x4_r;
  logic [ND_W-1:0]            num_r;
  logic [ND_W-1:0]            den_r;
  logic [ND_W-1:0]            rem_r;
  logic [Q_W-1:0]             lo_r;
  logic [Q_W-1:0]             q_r;
  logic [CNT_W-1:0]           cnt_r;

  // output register
  logic                       out_valid_r;
  logic [CH_W-1:0]            out_ch_r;
  logic signed [SAMPLE_W-1:0] out_data_r;

  // delay memory
  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_W-1:0] mem_rdata_r;
  logic                mem_re;
  logic                mem_we;
  logic [AW-1:0]       mem_raddr;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  // combinational helpers
  logic [CH_IW-1:0]           ch_idx;
  logic                       ch_ok;
  logic [AW-1:0]              base_addr;
  logic [PW-1:0]              wp_cur;
  logic [CW-1:0]              d_ext;
  logic [PW+FRAC_W-1:0]       d_clip;
  logic signed [RPW-1:0]      rp_raw;
  logic [RPW-1:0]             rp;
  logic [PW-1:0]              rp_idx;
  logic [PW-1:0]              rp_idxb;
  logic [COEF_W-1:0]          k_clip;
  logic [COEF_W-1:0]          g_clip;
  logic signed [SAMPLE_W-1:0] b_val;
  logic signed [24:0]         ab_diff;
  logic signed [33:0]         interp_sum;
  logic signed [32:0]         lp_diff;
  logic signed [50:0]         s_sum;
  logic signed [SAMPLE_W-1:0] arg;
  logic [47:0]                ax_sq;
  logic [47:0]                x2_sq;
  logic [57:0]                dvd;
  logic [ND_W-1:0]            div_rem;
  logic [Q_W-1:0]             div_lo;
  logic [Q_W-1:0]             div_q;
  logic [ND_W:0]              div_try;
  logic signed [25:0]         t_s;
  logic signed [25:0]         w_sum;
  logic signed [SAMPLE_W-1:0] w_sat;
  logic                       out_load;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_q8_r   <= DELAY_RST;
      fb_gain_r    <= FB_RST;
      damp_coeff_r <= DAMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELAY_Q8:      delay_q8_r   <= cfg_wdata[DELAY_W-1:0];
        REG_FEEDBACK_GAIN: fb_gain_r    <= cfg_wdata[COEF_W-1:0];
        REG_DAMP_COEFF:    damp_coeff_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // channel select, read position, coefficient clipping
  always_comb begin
    ch_idx    = CH_IW'(ch_r);
    ch_ok     = int'(ch_r) < CHANNELS;
    base_addr = (ch_r != '0) ? CH1_BASE : '0;
    wp_cur    = wp_r[ch_idx];
    d_ext     = CW'(delay_q8_r);
    d_clip    = (d_ext > DMAX) ? DMAX[PW+FRAC_W-1:0] : d_ext[PW+FRAC_W-1:0];
    rp_raw    = $signed({1'b0, wp_cur, {FRAC_W{1'b0}}}) - $signed({1'b0, d_clip});
    rp        = (rp_raw < 0) ? RPW'(rp_raw) + SPAN : RPW'(rp_raw);
    rp_idx    = rp[PW+FRAC_W-1:FRAC_W];
    rp_idxb   = (rp_idx == WP_LAST) ? '0 : rp_idx + PW'(1);
    k_clip    = (damp_coeff_r > COEF_ONE) ? COEF_ONE : damp_coeff_r;
    g_clip    = (fb_gain_r > COEF_ONE) ? COEF_ONE : fb_gain_r;
  end

  // interpolation, lowpass, tanh arguments
  always_comb begin
    b_val      = b_ok_r ? $signed(mem_rdata_r) : '0;
    ab_diff    = 25'(b_val) - 25'(a_r);
    interp_sum = 34'(a_r) + (prod_r >>> FRAC_W);
    lp_diff    = (33'(delayed_r) <<< FRAC_W) - 33'(damp_r[ch_idx]);
    s_sum      = 51'(damp_r[ch_idx]) + (lp_prod_r >>> 16);
    arg        = arg_prod_r[47:24];
    ax_sq      = 48'(ax_r) * 48'(ax_r);
    x2_sq      = 48'(x2_r) * 48'(x2_r);
    dvd        = 58'(ax_r) * 58'(num_r);
  end

  // restoring divider, DIV_BITS quotient bits per cycle
  always_comb begin
    div_rem = rem_r;
    div_lo  = lo_r;
    div_q   = q_r;
    div_try = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_try = {div_rem, div_lo[Q_W-1]};
      div_lo  = div_lo << 1;
      if (div_try >= {1'b0, den_r}) begin
        div_rem = ND_W'(div_try - {1'b0, den_r});
        div_q   = {div_q[Q_W-2:0], 1'b1};
      end else begin
        div_rem = div_try[ND_W-1:0];
        div_q   = {div_q[Q_W-2:0], 1'b0};
      end
    end
  end

  // write-back value: input plus signed tanh, saturated
  always_comb begin
    t_s   = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
    w_sum = 26'(x_r) + t_s;
    if (w_sum > 26'sd8388607) begin
      w_sat = 24'sh7FFFFF;
    end else if (w_sum < -26'sd8388608) begin
      w_sat = 24'sh800000;
    end else begin
      w_sat = w_sum[SAMPLE_W-1:0];
    end
  end

  // memory port control
  always_comb begin
    mem_re    = (state_r == S_RDA) || (state_r == S_RDB);
    mem_raddr = base_addr + AW'((state_r == S_RDA) ? idx_r : idxb_r);
    mem_we    = (state_r == S_WB);
    mem_waddr = base_addr + AW'(wp_cur);
    mem_wdata = w_sat;
    out_load  = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);
  end

  // delay memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]      <= '0;
        wrapped_r[c] <= 1'b0;
        damp_r[c]    <= '0;
      end
    end else begin
      // output valid: set on load, cleared when the sink takes the word
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            ch_r    <= in_chan.channel;
            x_r     <= in_chan.sample_in;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          idx_r  <= rp_idx;
          idxb_r <= rp_idxb;
          f_r    <= rp[FRAC_W-1:0];
          a_ok_r <= wrapped_r[ch_idx] || (rp_idx < wp_cur);
          b_ok_r <= wrapped_r[ch_idx] || (rp_idxb < wp_cur);
          skip_r <= !ch_ok;
          if (ch_ok) begin
            state_r <= S_RDA;
          end else begin
            a_r     <= '0;
            prod_r  <= '0;
            state_r <= S_OUT;
          end
        end
        S_RDA: state_r <= S_RDB;
        S_RDB: begin
          a_r     <= a_ok_r ? $signed(mem_rdata_r) : '0;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          prod_r  <= 34'(ab_diff) * 34'($signed({1'b0, f_r}));
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_ch_r    <= ch_r;
            out_data_r  <= interp_sum[SAMPLE_W-1:0];
            delayed_r   <= interp_sum[SAMPLE_W-1:0];
            state_r     <= skip_r ? S_IDLE : S_LP1;
          end
        end
        S_LP1: begin
          lp_prod_r <= 51'(lp_diff) * 51'($signed({1'b0, k_clip}));
          state_r   <= S_LP2;
        end
        S_LP2: begin
          s_r            <= s_sum[LP_W-1:0];
          damp_r[ch_idx] <= s_sum[LP_W-1:0];
          state_r        <= S_ARG;
        end
        S_ARG: begin
          arg_prod_r <= 50'(s_r) * 50'($signed({1'b0, g_clip}));
          state_r    <= S_ABS;
        end
        S_ABS: begin
          neg_r   <= arg[SAMPLE_W-1];
          ax_r    <= arg[SAMPLE_W-1] ? Q_W'(~arg + 1'b1) : Q_W'(arg);
          state_r <= S_X2;
        end
        S_X2: begin
          x2_r    <= ax_sq[TANH_Q+Q_W-1:TANH_Q];
          state_r <= S_X4;
        end
        S_X4: begin
          x4_r    <= x2_sq[TANH_Q+Q_W-1:TANH_Q];
          state_r <= S_ND;
        end
        S_ND: begin
          num_r   <= PADE_C0 + ND_W'(x2_r) * PADE_N2 + ND_W'(x4_r);
          den_r   <= PADE_C0 + ND_W'(x2_r) * PADE_D2 + ND_W'(x4_r) * PADE_D4;
          state_r <= S_MUL;
        end
        S_MUL: begin
          rem_r   <= dvd[57:Q_W];
          lo_r    <= dvd[Q_W-1:0];
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= div_rem;
          lo_r  <= div_lo;
          q_r   <= div_q;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          if (wp_cur == WP_LAST) begin
            wp_r[ch_idx]      <= '0;
            wrapped_r[ch_idx] <= 1'b1;
          end else begin
            wp_r[ch_idx] <= wp_cur + PW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ports
  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.channel_out = out_ch_r;
  assign out_chan.delayed_out = out_data_r;

endmodule
